>>> sv/ccw_pkg.sv
// shared types and constants for the text console cell writer
package ccw_pkg;

    localparam int DEF_COLUMNS   = 80;
    localparam int DEF_ROWS      = 25;
    localparam int DEF_TAB_WIDTH = 8;

    localparam int CELL_W       = 16;
    localparam int FIELD_ADDR_W = 11;

    localparam logic [7:0] ATTR_RESET     = 8'h0F;
    localparam logic [7:0] CHAR_BLANK     = 8'h20;
    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_LAST      = 8'h7F;

    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    typedef struct packed {
        logic       put;
        logic       home;
        logic [7:0] ch;
    } cursor_cmd_t;

    typedef struct packed {
        logic [FIELD_ADDR_W-1:0] cursor_offset;
        logic                    cell_written;
        logic [FIELD_ADDR_W-1:0] write_address;
        logic [CELL_W-1:0]       write_value;
        logic [CELL_W-1:0]       read_value;
    } result_t;

endpackage

>>> sv/ccw_cell_mem.sv
// cell store: one write port, one read port with registered read data
module ccw_cell_mem
    import ccw_pkg::*;
#(
    parameter int DEPTH  = DEF_ROWS * DEF_COLUMNS,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [CELL_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [CELL_W-1:0] rd_data
);

    logic [CELL_W-1:0] cell_mem [DEPTH];
    logic [CELL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cell_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= cell_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/ccw_cursor.sv
// cursor state and put-character interpretation
module ccw_cursor
    import ccw_pkg::*;
#(
    parameter int COLUMNS   = DEF_COLUMNS,
    parameter int ROWS      = DEF_ROWS,
    parameter int TAB_WIDTH = DEF_TAB_WIDTH,
    parameter int ADDR_W    = $clog2(ROWS * COLUMNS)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cursor_cmd_t             cmd,
    input  logic [7:0]              attr,
    output logic                    cell_we,
    output logic [ADDR_W-1:0]       cell_addr,
    output logic [CELL_W-1:0]       cell_value,
    output logic [FIELD_ADDR_W-1:0] write_address,
    output logic [FIELD_ADDR_W-1:0] offset
);

    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PH_W  = $clog2(TAB_WIDTH);
    localparam int TAB_W = COL_W + 5;
    localparam int OFF_W = (ADDR_W > FIELD_ADDR_W) ? ADDR_W : FIELD_ADDR_W;
    localparam logic [PH_W-1:0] LAST_COL_PHASE = PH_W'((COLUMNS - 1) % TAB_WIDTH);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [PH_W-1:0]  phase_reg, phase_next;

    logic [ROW_W-1:0]  row_adv;
    logic [TAB_W-1:0]  tab_col;
    logic [COL_W-1:0]  wcol;
    logic [7:0]        wchar;
    logic              we;
    logic              new_row;
    logic [ADDR_W-1:0] lin_w;
    logic [ADDR_W-1:0] lin_n;
    logic [OFF_W-1:0]  lin_w_ext;
    logic [OFF_W-1:0]  lin_n_ext;

    assign row_adv = (row_reg < ROW_W'(ROWS - 1)) ? row_reg + 1'b1 : row_reg;
    assign tab_col = TAB_W'(col_reg) - TAB_W'(phase_reg) + TAB_W'(TAB_WIDTH);

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        phase_next = phase_reg;
        we         = 1'b0;
        wcol       = col_reg;
        wchar      = CHAR_BLANK;
        new_row    = 1'b0;
        if (cmd.home)
        begin
            col_next   = '0;
            row_next   = '0;
            phase_next = '0;
        end
        else if (cmd.put)
        begin
            case (cmd.ch)
                CHAR_BACKSPACE:
                begin
                    if (col_reg == '0)
                    begin
                        // wrap to the end of the previous row (held at the top row), nothing blanked
                        col_next   = COL_W'(COLUMNS - 1);
                        phase_next = LAST_COL_PHASE;
                        if (row_reg != '0)
                        begin
                            row_next = row_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        col_next   = col_reg - 1'b1;
                        phase_next = (phase_reg == '0) ? PH_W'(TAB_WIDTH - 1)
                                                       : phase_reg - 1'b1;
                        we         = 1'b1;
                        wcol       = col_reg - 1'b1;
                    end
                end
                CHAR_TAB:
                begin
                    if (tab_col >= TAB_W'(COLUMNS))
                    begin
                        new_row = 1'b1;
                    end
                    else
                    begin
                        col_next   = tab_col[COL_W-1:0];
                        phase_next = '0;
                    end
                end
                CHAR_NEWLINE:
                begin
                    new_row = 1'b1;
                end
                default:
                begin
                    if (cmd.ch >= CHAR_BLANK && cmd.ch <= CHAR_LAST)
                    begin
                        we    = 1'b1;
                        wchar = cmd.ch;
                        if (col_reg == COL_W'(COLUMNS - 1))
                        begin
                            new_row = 1'b1;
                        end
                        else
                        begin
                            col_next   = col_reg + 1'b1;
                            phase_next = (phase_reg == PH_W'(TAB_WIDTH - 1)) ? '0
                                                                             : phase_reg + 1'b1;
                        end
                    end
                end
            endcase
            if (new_row)
            begin
                col_next   = '0;
                phase_next = '0;
                row_next   = row_adv;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            phase_reg <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            phase_reg <= phase_next;
        end
    end

    // linear index, exact modulo the address width since it stays below the cell count
    assign lin_w = ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(wcol);
    assign lin_n = ADDR_W'(row_next) * ADDR_W'(COLUMNS) + ADDR_W'(col_next);

    assign lin_w_ext = OFF_W'(lin_w);
    assign lin_n_ext = OFF_W'(lin_n);

    assign cell_we       = we;
    assign cell_addr     = we ? lin_w : '0;
    assign cell_value    = we ? {attr, wchar} : '0;
    assign write_address = we ? lin_w_ext[FIELD_ADDR_W-1:0] : '0;
    assign offset        = lin_n_ext[FIELD_ADDR_W-1:0];

endmodule

>>> sv/text_console_cell_writer.sv
// text console cell writer: request control, clear sweep and result buffering
//
// usage: requests enter on the input channel (in_valid / in_stall) with req_type,
// char_code and read_address; each request gives exactly one item on the output
// channel (out_valid / out_stall) carrying the cursor offset and any written or
// read cell. the attribute byte is written on cfg_valid / cfg_ready, always ready,
// and must only change while the block is idle.
// flow: put character and the unused request type push their result in the
// cycle they are accepted; a read first goes through the registered read of the
// cell memory; clear writes one cell per cycle through the single write port,
// and the input channel is stalled during the sweep.
// rate: one put character per cycle while the skid entry is free; a read stalls
// the input until its result is pushed. reset: cursor goes home, attribute to
// 0x0F; the cell store is not cleared and reads only valid data once a put or a
// clear has written it. output stall: results wait in the output register plus
// one skid entry; the input also stalls while the skid entry is occupied.
module text_console_cell_writer
    import ccw_pkg::*;
#(
    parameter int COLUMNS   = DEF_COLUMNS,
    parameter int ROWS      = DEF_ROWS,
    parameter int TAB_WIDTH = DEF_TAB_WIDTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [7:0]              cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              req_type,
    input  logic [7:0]              char_code,
    input  logic [FIELD_ADDR_W-1:0] read_address,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [FIELD_ADDR_W-1:0] cursor_offset,
    output logic                    cell_written,
    output logic [FIELD_ADDR_W-1:0] write_address,
    output logic [CELL_W-1:0]       write_value,
    output logic [CELL_W-1:0]       read_value
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int RA_W   = (CNT_W > FIELD_ADDR_W) ? CNT_W : FIELD_ADDR_W;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_READ  = 3'b010,
        ST_CLEAR = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic              range_reg;
    logic [7:0]        attr_reg;
    result_t           out_reg;
    logic              out_valid_reg;
    result_t           skid_reg;
    logic              skid_valid_reg;

    logic              in_acc;
    logic              out_free;
    logic              push;
    result_t           push_data;
    cursor_cmd_t       cmd;
    logic              rd_en;
    logic [RA_W-1:0]   raddr_ext;
    logic [CELL_W-1:0] rd_data;

    logic                    cur_we;
    logic [ADDR_W-1:0]       cur_addr;
    logic [CELL_W-1:0]       cur_value;
    logic [FIELD_ADDR_W-1:0] cur_waddr;
    logic [FIELD_ADDR_W-1:0] cur_offset;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE) | skid_valid_reg;
    assign in_acc    = in_valid & ~in_stall;

    assign cmd.put  = in_acc & (req_type == REQ_PUT);
    assign cmd.home = in_acc & (req_type == REQ_CLEAR);
    assign cmd.ch   = char_code;

    assign rd_en     = in_acc & (req_type == REQ_READ);
    assign raddr_ext = RA_W'(read_address);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            attr_reg <= cfg_data;
        end
    end

    ccw_cursor #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH),
        .ADDR_W    (ADDR_W)
    ) u_cursor (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .attr          (attr_reg),
        .cell_we       (cur_we),
        .cell_addr     (cur_addr),
        .cell_value    (cur_value),
        .write_address (cur_waddr),
        .offset        (cur_offset)
    );

    // clear sweep owns the write port; puts only happen while idle
    assign mem_we    = cur_we | (state_reg == ST_CLEAR);
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : cur_addr;
    assign mem_wdata = (state_reg == ST_CLEAR) ? {attr_reg, CHAR_BLANK} : cur_value;

    ccw_cell_mem #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_cell_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (rd_en),
        .rd_addr (raddr_ext[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next              = state_reg;
        clr_addr_next           = clr_addr_reg;
        push                    = 1'b0;
        push_data               = '0;
        push_data.cursor_offset = cur_offset;
        unique case (state_reg)
            ST_IDLE:
            begin
                clr_addr_next = '0;
                if (in_acc)
                begin
                    case (req_type)
                        REQ_PUT:
                        begin
                            push                    = 1'b1;
                            push_data.cell_written  = cur_we;
                            push_data.write_address = cur_waddr;
                            push_data.write_value   = cur_value;
                        end
                        REQ_CLEAR:
                        begin
                            state_next = ST_CLEAR;
                        end
                        REQ_READ:
                        begin
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            push = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                push                 = 1'b1;
                push_data.read_value = range_reg ? rd_data : '0;
                state_next           = ST_IDLE;
            end
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(CELLS - 1))
                begin
                    push       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            clr_addr_reg <= '0;
            range_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            if (rd_en)
            begin
                range_reg <= (raddr_ext < RA_W'(CELLS));
            end
        end
    end

    // output register with one skid entry behind it
    assign out_free = ~out_valid_reg | ~out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= push;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
                if (push)
                begin
                    skid_reg <= push_data;
                end
            end
            else if (push)
            begin
                out_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cursor_offset = out_reg.cursor_offset;
    assign cell_written  = out_reg.cell_written;
    assign write_address = out_reg.write_address;
    assign write_value   = out_reg.write_value;
    assign read_value    = out_reg.read_value;

endmodule

>>> dv/text_console_cell_writer_chk.sv
// checker for the text console cell writer: predicts each result and compares it
`timescale 1ns / 100ps

module text_console_cell_writer_chk
    import ccw_pkg::*;
#(
    parameter int COLUMNS   = DEF_COLUMNS,
    parameter int ROWS      = DEF_ROWS,
    parameter int TAB_WIDTH = DEF_TAB_WIDTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [7:0]              cfg_data,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic [1:0]              req_type,
    input  logic [7:0]              char_code,
    input  logic [FIELD_ADDR_W-1:0] read_address,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic [FIELD_ADDR_W-1:0] cursor_offset,
    input  logic                    cell_written,
    input  logic [FIELD_ADDR_W-1:0] write_address,
    input  logic [CELL_W-1:0]       write_value,
    input  logic [CELL_W-1:0]       read_value,
    input  logic                    end_of_test,
    output int                      error_count,
    output int                      pending
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int IDX_W = $clog2(CELLS);
    localparam int COL_W = $clog2(COLUMNS + 1);
    localparam int ROW_W = $clog2(ROWS + 1);
    localparam int PRINT_CAP = 100;

    logic [CELL_W-1:0] screen_cells [CELLS];
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [7:0]        attr_shadow;
    result_t           expected_results [$];
    bit                leftovers_checked;

    initial
    begin
        error_count = 0;
        leftovers_checked = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                   input logic [31:0] want_v);
        if (error_count < PRINT_CAP)
            $display("%0t mismatch %s: got %0h want %0h", $time, what, got_v, want_v);
        error_count = error_count + 1;
    endtask

    // move to column 0 of the next row, holding at the bottom row
    task automatic next_line();
        cursor_col = '0;
        if (cursor_row + 1 < ROWS)
            cursor_row = cursor_row + 1'b1;
    endtask

    task automatic apply_request(input logic [1:0] rq, input logic [7:0] ch,
                                 input logic [FIELD_ADDR_W-1:0] ra, output result_t r);
        logic       do_write;
        logic [7:0] wch;
        int         waddr;
        int         tab_stop;
        r = '0;
        do_write = 1'b0;
        wch = CHAR_BLANK;
        waddr = 0;
        case (rq)
            REQ_PUT:
            begin
                if (ch == CHAR_BACKSPACE)
                begin
                    if (cursor_col == 0)
                    begin
                        // wrap to the previous row (held at the top row), nothing is blanked
                        cursor_col = COL_W'(COLUMNS - 1);
                        if (cursor_row != 0)
                            cursor_row = cursor_row - 1'b1;
                    end
                    else
                    begin
                        cursor_col = cursor_col - 1'b1;
                        do_write = 1'b1;
                        wch = CHAR_BLANK;
                        waddr = cursor_row * COLUMNS + cursor_col;
                    end
                end
                else if (ch == CHAR_TAB)
                begin
                    tab_stop = cursor_col - cursor_col % TAB_WIDTH + TAB_WIDTH;
                    if (tab_stop >= COLUMNS)
                        next_line();
                    else
                        cursor_col = COL_W'(tab_stop);
                end
                else if (ch == CHAR_NEWLINE)
                begin
                    next_line();
                end
                else if (ch >= CHAR_BLANK && ch <= CHAR_LAST)
                begin
                    do_write = 1'b1;
                    wch = ch;
                    waddr = cursor_row * COLUMNS + cursor_col;
                    cursor_col = cursor_col + 1'b1;
                    if (cursor_col >= COLUMNS)
                        next_line();
                end
            end
            REQ_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    screen_cells[IDX_W'(i)] = {attr_shadow, CHAR_BLANK};
                cursor_col = '0;
                cursor_row = '0;
            end
            REQ_READ:
            begin
                if (ra < CELLS)
                    r.read_value = screen_cells[ra];
            end
            default:
            begin
            end
        endcase
        if (do_write)
        begin
            screen_cells[IDX_W'(waddr)] = {attr_shadow, wch};
            r.cell_written = 1'b1;
            r.write_address = FIELD_ADDR_W'(waddr);
            r.write_value = {attr_shadow, wch};
        end
        r.cursor_offset = FIELD_ADDR_W'(cursor_row * COLUMNS + cursor_col);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            cursor_col = '0;
            cursor_row = '0;
            attr_shadow = ATTR_RESET;
            expected_results.delete();
            pending <= 0;
        end
        else
        begin
            // results first: nothing accepted at this edge can come out at it
            if (out_valid && !out_stall)
            begin
                got = {cursor_offset, cell_written, write_address, write_value, read_value};
                if (expected_results.size() == 0)
                    report_mismatch("result with nothing expected",
                                    32'(got.cursor_offset), 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (got.cursor_offset !== want.cursor_offset)
                        report_mismatch("cursor_offset", 32'(got.cursor_offset),
                                        32'(want.cursor_offset));
                    if (got.cell_written !== want.cell_written)
                        report_mismatch("cell_written", 32'(got.cell_written),
                                        32'(want.cell_written));
                    if (got.write_address !== want.write_address)
                        report_mismatch("write_address", 32'(got.write_address),
                                        32'(want.write_address));
                    if (got.write_value !== want.write_value)
                        report_mismatch("write_value", 32'(got.write_value),
                                        32'(want.write_value));
                    if (got.read_value !== want.read_value)
                        report_mismatch("read_value", 32'(got.read_value),
                                        32'(want.read_value));
                end
            end
            if (cfg_valid && cfg_ready)
                attr_shadow = cfg_data;
            if (in_valid && !in_stall)
            begin
                apply_request(req_type, char_code, read_address, want);
                expected_results.push_back(want);
            end
            if (end_of_test && !leftovers_checked)
            begin
                leftovers_checked = 1;
                if (expected_results.size() != 0)
                    report_mismatch("results never delivered", expected_results.size(), 0);
            end
            pending <= expected_results.size();
        end
    end

endmodule

>>> dv/text_console_cell_writer_tb.sv
// testbench top for the text console cell writer: stimulus, receiver pattern and verdict
`timescale 1ns / 100ps

module text_console_cell_writer_tb;
    import ccw_pkg::*;

    localparam int         CLK_PERIOD     = 8;
    localparam int         ITEMS          = 1750;
    localparam int         PHASES         = 6;
    localparam int         LONG_HOLD      = 400;
    localparam int         SETTLE_CYCLES  = 8;
    localparam int         DRAIN_LIMIT    = 20000;
    localparam int         TIMEOUT_CYCLES = 1000000;
    localparam logic [1:0] REQ_UNUSED     = 2'd3;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [7:0]              cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic [1:0]              req_type;
    logic [7:0]              char_code;
    logic [FIELD_ADDR_W-1:0] read_address;
    logic                    out_valid;
    logic                    out_stall;
    logic [FIELD_ADDR_W-1:0] cursor_offset;
    logic                    cell_written;
    logic [FIELD_ADDR_W-1:0] write_address;
    logic [CELL_W-1:0]       write_value;
    logic [CELL_W-1:0]       read_value;
    logic                    end_of_test;
    logic                    long_hold_req;
    int                      error_count;
    int                      pending;

    int total_sent;
    int effective_sent;
    int clears_sent;
    int attr_writes;
    int burst_left;
    bit no_gaps;

    text_console_cell_writer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .char_code     (char_code),
        .read_address  (read_address),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cursor_offset (cursor_offset),
        .cell_written  (cell_written),
        .write_address (write_address),
        .write_value   (write_value),
        .read_value    (read_value)
    );

    text_console_cell_writer_chk checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .char_code     (char_code),
        .read_address  (read_address),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cursor_offset (cursor_offset),
        .cell_written  (cell_written),
        .write_address (write_address),
        .write_value   (write_value),
        .read_value    (read_value),
        .end_of_test   (end_of_test),
        .error_count   (error_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        repeat (TIMEOUT_CYCLES) @(posedge clk);
        $display("timeout with %0d results outstanding", pending);
        $display("DONE: errors detected");
        $finish;
    end

    // receiver: stall modes of random length, plus one long hold-off on request
    initial
    begin : receiver
        int mode;
        int mode_left;
        int hold_cycles;
        bit hold_taken;
        out_stall = 1'b0;
        mode = 0;
        mode_left = 0;
        hold_cycles = 0;
        hold_taken = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req && !hold_taken)
            begin
                hold_taken = 1;
                hold_cycles = LONG_HOLD;
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 4);
                    mode_left = $urandom_range(20, 300);
                end
                mode_left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= 1'($urandom_range(0, 1));
                    3: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= (mode_left % 3 == 0);
                endcase
            end
        end
    end

    function automatic bit has_effect(input logic [1:0] rq, input logic [7:0] ch);
        if (rq == REQ_PUT)
            return ch == CHAR_BACKSPACE || ch == CHAR_TAB || ch == CHAR_NEWLINE ||
                   (ch >= CHAR_BLANK && ch <= CHAR_LAST);
        return rq != REQ_UNUSED;
    endfunction

    // offer one item, opening a new burst after a random gap when the last one ran out
    task automatic push_request(input logic [1:0] rq, input logic [7:0] ch,
                                input logic [FIELD_ADDR_W-1:0] ra);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = no_gaps ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                req_type <= 2'($urandom);
                char_code <= 8'($urandom);
                read_address <= FIELD_ADDR_W'($urandom);
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        req_type <= rq;
        char_code <= ch;
        read_address <= ra;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        total_sent++;
        if (has_effect(rq, ch))
            effective_sent++;
        if (rq == REQ_CLEAR)
            clears_sent++;
    endtask

    // wait until every expected result has come back, then let the pipe drain
    task automatic settle();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        @(posedge clk);
        while (pending != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int target;
        int kind;
        int run_len;
        int pick;
        logic [7:0] attr_value;
        logic [1:0] rq;
        logic [FIELD_ADDR_W-1:0] ra;

        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        req_type = REQ_PUT;
        char_code = '0;
        read_address = '0;
        end_of_test = 1'b0;
        long_hold_req = 1'b0;
        total_sent = 0;
        effective_sent = 0;
        clears_sent = 0;
        attr_writes = 0;
        burst_left = 0;
        no_gaps = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: clear first so that every cell holds a known value before any read
        push_request(REQ_CLEAR, 8'h00, '0);
        push_request(REQ_READ, 8'hFF, '0);
        push_request(REQ_PUT, 8'h41, '1);
        push_request(REQ_PUT, CHAR_BLANK, '0);
        push_request(REQ_PUT, CHAR_LAST, '0);
        push_request(REQ_READ, 8'h00, 11'd2);
        push_request(REQ_PUT, 8'h1F, '0);
        push_request(REQ_PUT, 8'h80, '0);
        push_request(REQ_PUT, 8'hFF, '1);
        push_request(REQ_PUT, 8'h00, '0);
        push_request(REQ_PUT, CHAR_BACKSPACE, '0);
        push_request(REQ_READ, 8'h00, 11'd2);
        push_request(REQ_PUT, CHAR_TAB, '0);
        push_request(REQ_PUT, CHAR_TAB, '0);
        push_request(REQ_PUT, CHAR_NEWLINE, '0);
        // backspace at column 0 goes to the end of the row above
        push_request(REQ_PUT, CHAR_BACKSPACE, '0);
        // printable in the last column wraps to the next row
        push_request(REQ_PUT, 8'h5A, '0);
        push_request(REQ_PUT, CHAR_BACKSPACE, '0);
        // tab from the last column wraps to the next row
        push_request(REQ_PUT, CHAR_TAB, '0);
        push_request(REQ_READ, 8'h00, 11'd79);
        push_request(REQ_UNUSED, 8'hFF, '1);
        push_request(REQ_READ, 8'h00, 11'd1999);
        push_request(REQ_READ, 8'h00, 11'd2000);
        push_request(REQ_READ, 8'h00, '1);
        push_request(REQ_CLEAR, 8'hFF, '1);
        // backspace at home holds the row at the top
        push_request(REQ_PUT, CHAR_BACKSPACE, '0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            case (phase)
                0: attr_value = 8'h00;
                1: attr_value = 8'hFF;
                4: attr_value = ATTR_RESET;
                default: attr_value = 8'($urandom);
            endcase
            cfg_valid <= 1'b1;
            cfg_data <= attr_value;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cfg_valid <= 1'b0;
            attr_writes++;

            if (phase == 2)
            begin
                // receiver holds off while the sender keeps pushing text
                long_hold_req <= 1'b1;
                no_gaps = 1;
                for (int i = 0; i < 60; i++)
                    push_request(REQ_PUT, 8'($urandom_range(8'h20, 8'h7F)), FIELD_ADDR_W'($urandom));
                no_gaps = 0;
            end

            target = effective_sent + ITEMS / PHASES;
            while (effective_sent < target)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 6)
                begin
                    push_request(REQ_CLEAR, 8'($urandom), FIELD_ADDR_W'($urandom));
                end
                else if (kind < 46)
                begin
                    // text with the odd control byte
                    run_len = $urandom_range(1, 100);
                    for (int i = 0; i < run_len; i++)
                    begin
                        pick = $urandom_range(0, 99);
                        if (pick < 8)
                            push_request(REQ_PUT, CHAR_TAB, FIELD_ADDR_W'($urandom));
                        else if (pick < 12)
                            push_request(REQ_PUT, CHAR_NEWLINE, FIELD_ADDR_W'($urandom));
                        else if (pick < 16)
                            push_request(REQ_PUT, CHAR_BACKSPACE, FIELD_ADDR_W'($urandom));
                        else
                            push_request(REQ_PUT, 8'($urandom_range(8'h20, 8'h7F)),
                                         FIELD_ADDR_W'($urandom));
                    end
                end
                else if (kind < 54)
                begin
                    // a run of newlines that often reaches the bottom row, then text written after it
                    run_len = $urandom_range(20, 30);
                    for (int i = 0; i < run_len; i++)
                        push_request(REQ_PUT, CHAR_NEWLINE, FIELD_ADDR_W'($urandom));
                    run_len = $urandom_range(1, 10);
                    for (int i = 0; i < run_len; i++)
                        push_request(REQ_PUT, 8'($urandom_range(8'h20, 8'h7F)),
                                     FIELD_ADDR_W'($urandom));
                end
                else if (kind < 64)
                begin
                    run_len = $urandom_range(1, 120);
                    for (int i = 0; i < run_len; i++)
                        push_request(REQ_PUT, CHAR_BACKSPACE, FIELD_ADDR_W'($urandom));
                end
                else if (kind < 71)
                begin
                    run_len = $urandom_range(1, 25);
                    for (int i = 0; i < run_len; i++)
                    begin
                        push_request(REQ_PUT, CHAR_TAB, FIELD_ADDR_W'($urandom));
                        if ($urandom_range(0, 1))
                            push_request(REQ_PUT, 8'($urandom_range(8'h20, 8'h7F)),
                                         FIELD_ADDR_W'($urandom));
                    end
                end
                else if (kind < 86)
                begin
                    // reads mostly over the top rows where text piles up
                    run_len = $urandom_range(1, 16);
                    for (int i = 0; i < run_len; i++)
                    begin
                        pick = $urandom_range(0, 99);
                        if (pick < 80)
                            ra = FIELD_ADDR_W'($urandom_range(0, 399));
                        else if (pick < 95)
                            ra = FIELD_ADDR_W'($urandom_range(0, 1999));
                        else
                            ra = FIELD_ADDR_W'($urandom_range(2000, 2047));
                        push_request(REQ_READ, 8'($urandom), ra);
                    end
                end
                else
                begin
                    // noise: any byte, any request but clear, any address
                    run_len = $urandom_range(1, 10);
                    for (int i = 0; i < run_len; i++)
                    begin
                        rq = 2'($urandom_range(0, 3));
                        if (rq == REQ_CLEAR)
                            rq = REQ_PUT;
                        push_request(rq, 8'($urandom), FIELD_ADDR_W'($urandom));
                    end
                end
            end
        end

        settle();
        end_of_test <= 1'b1;
        repeat (2) @(posedge clk);
        $display("covered %0d requests (%0d with effect), %0d clears, %0d attribute settings",
                 total_sent, effective_sent, clears_sent, attr_writes);
        $display("sender bursts and gaps, receiver stall patterns and one %0d-cycle hold-off",
                 LONG_HOLD);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
